FILE: rtl/core/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// Shared sizes and helpers for the quicksort engine.
// ----------------------------------------------------------------------------
package qse_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SK_W     = 2 * IDX_W;

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Signed order of two stored words.
    function automatic logic key_le(input t_word a, input t_word b);
        key_le = $signed(a) <= $signed(b);
    endfunction

    function automatic logic key_ge(input t_word a, input t_word b);
        key_ge = $signed(a) >= $signed(b);
    endfunction

endpackage

FILE: rtl/core/qse_if.sv
// ----------------------------------------------------------------------------
// qse_if
// Valid/ready channels of the quicksort engine.
// ----------------------------------------------------------------------------
interface qse_in_if
    import qse_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word value;
    logic  last_in;

    modport source (output valid, output value, output last_in, input ready);
    modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface qse_out_if
    import qse_pkg::*;
;
    logic  valid;
    logic  ready;
    t_word sorted_value;
    logic  last_out;

    modport source (output valid, output sorted_value, output last_out, input ready);
    modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

FILE: rtl/core/qse_ram.sv
// ----------------------------------------------------------------------------
// qse_ram
// Simple dual-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module qse_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/quicksort_engine.sv
// Loading: input is taken only in the load state; the item marked last ends the set.
// Sorting: partition passes over ranges popped from the range stack until it is empty.
// Emission: one transfer per cycle while the receiver holds ready high.
// Reset (synchronous, active low) clears state, count, stack pointer and the
// output valid; memory contents are not cleared.
// ----------------------------------------------------------------------------
// quicksort_engine
// In-place quicksort over a small element memory with a range stack memory.
// ----------------------------------------------------------------------------
module quicksort_engine
    import qse_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    qse_in_if.sink           i_in,
    qse_out_if.source        o_out
);

    typedef enum logic [3:0] {
        S_LOAD, S_INIT, S_POP, S_POPW, S_PIV, S_CHKL, S_CHKR, S_SWP2,
        S_FINRD, S_WLO, S_WMID, S_PUSH, S_EMIT
    } t_state;

    t_state r_state, n_state;
    t_cnt   r_cnt, n_cnt, r_sp, n_sp;
    t_idx   r_lo, n_lo, r_hi, n_hi, r_l, n_l, r_r, n_r, r_mid, n_mid, r_k, n_k;
    t_word  r_piv, n_piv, r_lval, n_lval, r_mval, n_mval;
    logic   r_ov, n_ov, r_olast, n_olast;
    t_word  r_odata, n_odata;

    logic            st_we, st_re;
    t_idx            st_waddr, st_raddr;
    t_word           st_wdata, st_rdata;
    logic            sk_we, sk_re;
    t_idx            sk_waddr, sk_raddr;
    logic [SK_W-1:0] sk_wdata, sk_rdata;

    logic w_acc, w_slot;
    t_cnt w_mid1;

    qse_ram #(.DEPTH(CAPACITY), .WIDTH(DATA_W)) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    qse_ram #(.DEPTH(CAPACITY), .WIDTH(SK_W)) u_stack (
        .i_clk   (i_clk),
        .i_we    (sk_we),
        .i_waddr (sk_waddr),
        .i_wdata (sk_wdata),
        .i_re    (sk_re),
        .i_raddr (sk_raddr),
        .o_rdata (sk_rdata)
    );

    assign i_in.ready         = (r_state == S_LOAD);
    assign w_acc              = i_in.valid && (r_state == S_LOAD);
    assign w_slot             = !r_ov || o_out.ready;
    assign w_mid1             = {1'b0, r_mid} + t_cnt'(1);
    assign o_out.valid        = r_ov;
    assign o_out.sorted_value = r_odata;
    assign o_out.last_out     = r_olast;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sp     = r_sp;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_l      = r_l;
        n_r      = r_r;
        n_mid    = r_mid;
        n_k      = r_k;
        n_piv    = r_piv;
        n_lval   = r_lval;
        n_mval   = r_mval;
        n_ov     = r_ov && !o_out.ready;
        n_odata  = r_odata;
        n_olast  = r_olast;
        st_we    = 1'b0;
        st_waddr = '0;
        st_wdata = '0;
        st_re    = 1'b0;
        st_raddr = '0;
        sk_we    = 1'b0;
        sk_waddr = '0;
        sk_wdata = '0;
        sk_re    = 1'b0;
        sk_raddr = '0;

        case (r_state)
            S_LOAD: begin
                if (w_acc) begin
                    if (r_cnt < t_cnt'(CAPACITY)) begin
                        st_we    = 1'b1;
                        st_waddr = r_cnt[IDX_W-1:0];
                        st_wdata = i_in.value;
                        n_cnt    = r_cnt + t_cnt'(1);
                    end
                    if (i_in.last_in) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                if (r_cnt < t_cnt'(2)) begin
                    st_re    = 1'b1;
                    st_raddr = '0;
                    n_k      = '0;
                    n_state  = S_EMIT;
                end else begin
                    sk_we    = 1'b1;
                    sk_waddr = '0;
                    sk_wdata = {t_idx'(0), t_idx'(r_cnt - t_cnt'(1))};
                    n_sp     = t_cnt'(1);
                    n_state  = S_POP;
                end
            end
            S_POP: begin
                if (r_sp == '0) begin
                    st_re    = 1'b1;
                    st_raddr = '0;
                    n_k      = '0;
                    n_state  = S_EMIT;
                end else begin
                    sk_re    = 1'b1;
                    sk_raddr = t_idx'(r_sp - t_cnt'(1));
                    n_sp     = r_sp - t_cnt'(1);
                    n_state  = S_POPW;
                end
            end
            S_POPW: begin
                n_lo     = sk_rdata[SK_W-1:IDX_W];
                n_hi     = sk_rdata[IDX_W-1:0];
                st_re    = 1'b1;
                st_raddr = sk_rdata[SK_W-1:IDX_W];
                n_state  = S_PIV;
            end
            S_PIV: begin
                n_piv    = st_rdata;
                n_l      = r_lo;
                n_r      = r_hi;
                st_re    = 1'b1;
                st_raddr = r_lo;
                n_state  = S_CHKL;
            end
            S_CHKL: begin
                // Read data holds the element at the left index.
                st_re = 1'b1;
                if (r_l < r_r && key_le(st_rdata, r_piv)) begin
                    n_l      = r_l + t_idx'(1);
                    st_raddr = r_l + t_idx'(1);
                end else begin
                    n_lval   = st_rdata;
                    st_raddr = r_r;
                    n_state  = S_CHKR;
                end
            end
            S_CHKR: begin
                // Read data holds the element at the right index.
                if (r_l < r_r && key_ge(st_rdata, r_piv)) begin
                    n_r      = r_r - t_idx'(1);
                    st_re    = 1'b1;
                    st_raddr = r_r - t_idx'(1);
                end else if (r_l < r_r) begin
                    st_we    = 1'b1;
                    st_waddr = r_l;
                    st_wdata = st_rdata;
                    n_state  = S_SWP2;
                end else if (key_le(st_rdata, r_piv) || r_l == r_lo) begin
                    // Both indices met; the element there is the one read.
                    n_mid   = r_l;
                    n_mval  = st_rdata;
                    n_state = S_WLO;
                end else begin
                    n_mid    = r_l - t_idx'(1);
                    st_re    = 1'b1;
                    st_raddr = r_l - t_idx'(1);
                    n_state  = S_FINRD;
                end
            end
            S_SWP2: begin
                st_we    = 1'b1;
                st_waddr = r_r;
                st_wdata = r_lval;
                st_re    = 1'b1;
                st_raddr = r_l;
                n_state  = S_CHKL;
            end
            S_FINRD: begin
                n_mval  = st_rdata;
                n_state = S_WLO;
            end
            S_WLO: begin
                st_we    = 1'b1;
                st_waddr = r_lo;
                st_wdata = r_mval;
                n_state  = S_WMID;
            end
            S_WMID: begin
                st_we    = 1'b1;
                st_waddr = r_mid;
                st_wdata = r_piv;
                if (r_mid > r_lo && (r_mid - t_idx'(1)) > r_lo
                        && r_sp < t_cnt'(CAPACITY)) begin
                    sk_we    = 1'b1;
                    sk_waddr = r_sp[IDX_W-1:0];
                    sk_wdata = {r_lo, r_mid - t_idx'(1)};
                    n_sp     = r_sp + t_cnt'(1);
                end
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (w_mid1 < {1'b0, r_hi} && r_sp < t_cnt'(CAPACITY)) begin
                    sk_we    = 1'b1;
                    sk_waddr = r_sp[IDX_W-1:0];
                    sk_wdata = {w_mid1[IDX_W-1:0], r_hi};
                    n_sp     = r_sp + t_cnt'(1);
                end
                n_state = S_POP;
            end
            S_EMIT: begin
                if (w_slot) begin
                    n_ov    = 1'b1;
                    n_odata = st_rdata;
                    n_olast = ({1'b0, r_k} + t_cnt'(1)) == r_cnt;
                    if (({1'b0, r_k} + t_cnt'(1)) == r_cnt) begin
                        n_cnt   = '0;
                        n_sp    = '0;
                        n_state = S_LOAD;
                    end else begin
                        n_k      = r_k + t_idx'(1);
                        st_re    = 1'b1;
                        st_raddr = r_k + t_idx'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_sp    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sp    <= n_sp;
            r_ov    <= n_ov;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_l     <= n_l;
        r_r     <= n_r;
        r_mid   <= n_mid;
        r_k     <= n_k;
        r_piv   <= n_piv;
        r_lval  <= n_lval;
        r_mval  <= n_mval;
        r_odata <= n_odata;
        r_olast <= n_olast;
    end

    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= t_cnt'(CAPACITY))
        else $error("range stack pointer beyond capacity");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= t_cnt'(CAPACITY))
        else $error("item count beyond capacity");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHKL || r_state == S_CHKR) |-> r_l <= r_r)
        else $error("partition scan indices crossed");

    a_emit_more: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_out) |-> r_state == S_EMIT)
        else $error("emission stopped before the final value");

endmodule

FILE: verif/tb_quicksort_engine.sv
// ----------------------------------------------------------------------------
// tb_quicksort_engine
// Loads sets of signed words into the sorter, predicts each set's ascending
// order, and checks every output transfer against it. Both channels idle at
// random. One phase holds the output off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_quicksort_engine;
    import qse_pkg::*;

    localparam int ITEMS_TARGET = 500;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_GAP      = 8;

    typedef struct {
        t_word value;
        logic  last;
    } t_sorted_word;

    logic i_clk;
    logic i_rst_n;

    qse_in_if  in_bus ();
    qse_out_if out_bus ();

    quicksort_engine u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Words held by the predictor for the set being loaded.
    t_word        held [CAPACITY];
    int           held_count;
    t_sorted_word pending_sorted[$];

    int  errors;
    int  items_loaded;
    int  cycle_count;
    bit  in_idle;
    bit  out_idle;
    int  result_gap;
    int  hold_left;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input t_word got, input t_word want);
        $display("ERROR %0s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
        errors++;
    endtask

    // Stores a word unless the set is already full; the last flag sorts the
    // held words by signed value and queues them in ascending order.
    function automatic void load_and_sort(input t_word v, input logic last);
        t_word key;
        int    j;
        if (held_count < CAPACITY) begin
            held[held_count] = v;
            held_count++;
            items_loaded++;
        end
        if (!last)
            return;
        for (int i = 1; i < held_count; i++) begin
            key = held[i];
            j   = i - 1;
            while (j >= 0 && $signed(held[j]) > $signed(key)) begin
                held[j + 1] = held[j];
                j--;
            end
            held[j + 1] = key;
        end
        for (int k = 0; k < held_count; k++)
            pending_sorted.push_back('{value: held[k], last: (k == held_count - 1)});
        held_count = 0;
    endfunction

    // Output side: after every transfer the receiver may pause, and a
    // requested hold-off keeps ready low for a counted stretch.
    initial begin
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_bus.ready = 1'b0;
                hold_left--;
            end else if (result_gap > 0) begin
                out_bus.ready = 1'b0;
                result_gap--;
            end else begin
                out_bus.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_sorted_word want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_sorted.size() == 0) begin
                report_mismatch("unexpected sorted_value", out_bus.sorted_value, '0);
            end else begin
                want = pending_sorted.pop_front();
                if (out_bus.sorted_value !== want.value)
                    report_mismatch("sorted_value", out_bus.sorted_value, want.value);
                if (out_bus.last_out !== want.last)
                    report_mismatch("last_out", t_word'(out_bus.last_out), t_word'(want.last));
            end
            result_gap = out_idle ? $urandom_range(0, MAX_GAP) : 0;
        end
    end

    task automatic send_word(input t_word v, input logic last);
        int gap;
        gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid   = 1'b1;
        in_bus.value   = v;
        in_bus.last_in = last;
        do @(posedge i_clk); while (!in_bus.ready);
        load_and_sort(v, last);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        in_bus.valid = 1'b0;
        while (pending_sorted.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic t_word random_word();
        case ($urandom_range(0, 5))
            0, 1, 2: return t_word'($urandom);
            3:       return t_word'($signed($urandom_range(0, 8)) - 4);
            4: begin
                case ($urandom_range(0, 3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return t_word'($urandom_range(0, 3))
                            ^ {($urandom_range(0, 1) == 1), 31'h0};
        endcase
    endfunction

    task automatic send_random_set(input int size);
        for (int i = 0; i < size; i++)
            send_word(random_word(), i == size - 1);
    endtask

    task automatic test_directed();
        t_word mix [10];
        in_idle  = 1'b0;
        out_idle = 1'b0;
        // A set of one comes back unchanged and marked last.
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h7fff_ffff, 1'b1);
        mix = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
                32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'hffff_ffff,
                32'h8000_0001, 32'h0000_0000};
        for (int i = 0; i < 10; i++)
            send_word(mix[i], i == 9);
        wait_drained();
    endtask

    task automatic test_store_full();
        in_idle  = 1'b1;
        out_idle = 1'b1;
        // The last flag rides on a word that no longer fits; the held set
        // must still be sorted and sent.
        for (int i = 0; i < CAPACITY + 1; i++)
            send_word(t_word'(CAPACITY - i), i == CAPACITY);
        wait_drained();
    endtask

    task automatic test_output_stall();
        in_idle  = 1'b0;
        out_idle = 1'b0;
        @(posedge i_clk);
        hold_left = 400;
        send_random_set(CAPACITY);
        send_random_set(CAPACITY);
        send_random_set(5);
        wait_drained();
    endtask

    task automatic test_random_sets();
        int size;
        while (items_loaded < ITEMS_TARGET) begin
            in_idle  = ($urandom_range(0, 3) != 0);
            out_idle = ($urandom_range(0, 3) != 0);
            size = ($urandom_range(0, 9) == 0) ? $urandom_range(CAPACITY + 1, CAPACITY + 4)
                                               : $urandom_range(1, CAPACITY);
            send_random_set(size);
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        errors         = 0;
        items_loaded   = 0;
        cycle_count    = 0;
        held_count     = 0;
        in_idle        = 1'b0;
        out_idle       = 1'b0;
        result_gap     = 0;
        hold_left      = 0;
        in_bus.valid   = 1'b0;
        in_bus.value   = '0;
        in_bus.last_in = 1'b0;
        i_rst_n        = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_store_full();
        test_output_stall();
        test_random_sets();

        // Give any stray output time to show up.
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
